// ----- design/tgf_pkg.sv -----
// Shared types and codes of the team grouped FIFO.
package tgf_pkg;

   typedef enum logic [1:0] {
      CMD_SET = 2'd0,
      CMD_ENQ = 2'd1,
      CMD_DEQ = 2'd2,
      CMD_CLR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ENQ_TEAM,
      S_ENQ_LINK,
      S_DEQ_TEAM,
      S_DEQ_SLOT,
      S_DEQ_OUT
   } state_type;

   typedef struct packed {
      logic alloc;
      logic give_back;
      logic flush;
   } pool_ctrl_type;

endpackage

// ----- design/team_grouped_fifo_core.sv -----
// Team grouped FIFO core: membership table, per-team linked groups and team order ring.
// Commands enter on start while busy is low; every result shows on the rsp_ ports for one
// cycle under rsp_strobe and cannot be held off. A membership load leaves busy low; an
// enqueue on a full pool or a dequeue on an empty queue answers the next cycle. An enqueue
// joining a new group answers from S_ENQ_TEAM; one linking behind the team's tail goes on
// to S_ENQ_LINK after one more read of the tail memory. A dequeue passes S_DEQ_TEAM,
// S_DEQ_SLOT and S_DEQ_OUT, set by the chain of registered reads through the team order,
// head and link memories. A clear, and reset, sweeps the membership memory one entry a
// cycle with busy high. Slot, order and group state are cleared at once, without a sweep.
module team_grouped_fifo_core #(
   parameter int TEAMS        = 16,
   parameter int ELEMENT_BITS = 10,
   parameter int CAPACITY     = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_cmd,
   input  logic [ELEMENT_BITS-1:0] req_element,
   input  logic [3:0]              req_team,
   output logic                    rsp_strobe,
   output logic [ELEMENT_BITS-1:0] rsp_element_out,
   output logic [1:0]              rsp_status
);
   import tgf_pkg::*;

   localparam int N_ELEMS = 1 << ELEMENT_BITS;
   localparam int EW      = ELEMENT_BITS;
   localparam int TW      = (TEAMS > 1) ? $clog2(TEAMS) : 1;
   localparam int SW      = $clog2(CAPACITY);

   state_type state_ff, state_in;
   cmd_type   cmd;
   logic      accept;

   logic [TW-1:0] team_mem  [N_ELEMS];
   logic [EW-1:0] elem_mem  [CAPACITY];
   logic [SW-1:0] link_mem  [CAPACITY];
   logic [SW-1:0] head_mem  [TEAMS];
   logic [SW-1:0] tail_mem  [TEAMS];
   logic [TW-1:0] order_mem [TEAMS];

   logic [TW-1:0] team_q_ff;
   logic [EW-1:0] elem_q_ff;
   logic [SW-1:0] link_q_ff;
   logic [SW-1:0] head_q_ff;
   logic [SW-1:0] tail_q_ff;
   logic [TW-1:0] order_q_ff;

   logic [EW-1:0]    sweep_ff;
   logic [EW-1:0]    elem_ff;
   logic [TW-1:0]    team_ff;
   logic [SW-1:0]    slot_ff;
   logic             last_ff;
   logic [TEAMS-1:0] waiting_ff;
   logic [TW-1:0]    ohead_ff;
   logic [TW-1:0]    otail_ff;
   logic [TW:0]      ocount_ff;
   logic             rsp_strobe_ff;
   logic [EW-1:0]    rsp_element_ff;
   logic [1:0]       rsp_status_ff;

   pool_ctrl_type pool_ctrl;
   logic [SW-1:0] pool_slot;
   logic          none_free;

   logic          team_we;
   logic [EW-1:0] team_wa;
   logic [TW-1:0] team_wd;
   logic          elem_we;
   logic          link_we;
   logic          head_we;
   logic [TW-1:0] head_wa;
   logic [SW-1:0] head_wd;
   logic          tail_we;
   logic [TW-1:0] tail_wa;
   logic [SW-1:0] tail_wd;
   logic [TW-1:0] tail_ra;
   logic          order_we;
   logic          new_group;
   logic          drop_group;
   logic          rsp_set;
   logic [1:0]    rsp_status_in;
   logic [EW-1:0] rsp_element_in;

   assign busy            = (state_ff != S_IDLE);
   assign accept          = start && !busy;
   assign cmd             = cmd_type'(req_cmd);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_element_out = rsp_element_ff;
   assign rsp_status      = rsp_status_ff;

   tgf_slot_pool #(
      .CAPACITY(CAPACITY)
   ) u_slot_pool (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pool_ctrl),
      .give_slot (head_q_ff),
      .alloc_slot(pool_slot),
      .none_free (none_free)
   );

   function automatic logic [TW-1:0] ring_next(input logic [TW-1:0] ptr);
      logic [TW-1:0] nxt;
      nxt = (ptr == TW'(TEAMS - 1)) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sweep_ff == EW'(N_ELEMS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_ENQ: begin
                     if (!none_free) begin
                        state_in = S_ENQ_TEAM;
                     end
                  end
                  CMD_DEQ: begin
                     if (ocount_ff != '0) begin
                        state_in = S_DEQ_TEAM;
                     end
                  end
                  CMD_CLR: state_in = S_CLEAR;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ENQ_TEAM: state_in = waiting_ff[team_q_ff] ? S_ENQ_LINK : S_IDLE;
         S_ENQ_LINK: state_in = S_IDLE;
         S_DEQ_TEAM: state_in = S_DEQ_SLOT;
         S_DEQ_SLOT: state_in = S_DEQ_OUT;
         S_DEQ_OUT:  state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pool_ctrl      = '0;
      team_we        = 1'b0;
      team_wa        = req_element;
      team_wd        = TW'(req_team);
      elem_we        = 1'b0;
      link_we        = 1'b0;
      head_we        = 1'b0;
      head_wa        = team_q_ff;
      head_wd        = pool_slot;
      tail_we        = 1'b0;
      tail_wa        = team_q_ff;
      tail_wd        = pool_slot;
      tail_ra        = order_q_ff;
      order_we       = 1'b0;
      new_group      = 1'b0;
      drop_group     = 1'b0;
      rsp_set        = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_element_in = '0;
      case (state_ff)
         S_CLEAR: begin
            team_we = 1'b1;
            team_wa = sweep_ff;
            team_wd = '0;
         end
         S_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_SET: team_we = (32'(req_team) < TEAMS);
                  CMD_ENQ: begin
                     if (none_free) begin
                        rsp_set       = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        pool_ctrl.alloc = 1'b1;
                     end
                  end
                  CMD_DEQ: begin
                     if (ocount_ff == '0) begin
                        rsp_set       = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end
                  end
                  CMD_CLR: pool_ctrl.flush = 1'b1;
                  default: pool_ctrl = '0;
               endcase
            end
         end
         S_ENQ_TEAM: begin
            elem_we = 1'b1;
            tail_ra = team_q_ff;
            if (!waiting_ff[team_q_ff]) begin
               head_we   = 1'b1;
               tail_we   = 1'b1;
               order_we  = 1'b1;
               new_group = 1'b1;
               rsp_set   = 1'b1;
            end
         end
         S_ENQ_LINK: begin
            link_we = 1'b1;
            tail_we = 1'b1;
            tail_wa = team_ff;
            tail_wd = slot_ff;
            rsp_set = 1'b1;
         end
         S_DEQ_SLOT: begin
            pool_ctrl.give_back = 1'b1;
            drop_group          = (head_q_ff == tail_q_ff);
         end
         S_DEQ_OUT: begin
            rsp_set        = 1'b1;
            rsp_element_in = elem_q_ff;
            head_we        = !last_ff;
            head_wa        = team_ff;
            head_wd        = link_q_ff;
         end
         default: rsp_set = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (team_we) begin
         team_mem[team_wa] <= team_wd;
      end
      team_q_ff <= team_mem[req_element];
      if (elem_we) begin
         elem_mem[pool_slot] <= elem_ff;
      end
      elem_q_ff <= elem_mem[head_q_ff];
      if (link_we) begin
         link_mem[tail_q_ff] <= slot_ff;
      end
      link_q_ff <= link_mem[head_q_ff];
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_q_ff <= head_mem[order_q_ff];
      if (tail_we) begin
         tail_mem[tail_wa] <= tail_wd;
      end
      tail_q_ff <= tail_mem[tail_ra];
      if (order_we) begin
         order_mem[otail_ff] <= team_q_ff;
      end
      order_q_ff <= order_mem[ohead_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elem_ff <= req_element;
      end
      if (state_ff == S_ENQ_TEAM) begin
         team_ff <= team_q_ff;
         slot_ff <= pool_slot;
      end
      if (state_ff == S_DEQ_TEAM) begin
         team_ff <= order_q_ff;
      end
      if (state_ff == S_DEQ_SLOT) begin
         last_ff <= drop_group;
      end
      if (rsp_set) begin
         rsp_element_ff <= rsp_element_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         sweep_ff      <= '0;
         waiting_ff    <= '0;
         ohead_ff      <= '0;
         otail_ff      <= '0;
         ocount_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= (state_ff == S_CLEAR) ? sweep_ff + 1'b1 : '0;
         rsp_strobe_ff <= rsp_set;
         if (pool_ctrl.flush) begin
            waiting_ff <= '0;
            ohead_ff   <= '0;
            otail_ff   <= '0;
            ocount_ff  <= '0;
         end
         if (new_group) begin
            waiting_ff[team_q_ff] <= 1'b1;
            otail_ff              <= ring_next(otail_ff);
            ocount_ff             <= ocount_ff + 1'b1;
         end
         if (drop_group) begin
            waiting_ff[team_ff] <= 1'b0;
            ohead_ff            <= ring_next(ohead_ff);
            ocount_ff           <= ocount_ff - 1'b1;
         end
      end
   end

endmodule

// ----- design/tgf_slot_pool.sv -----
// Free slot pool: a stack of returned slots in memory plus a high-water count.
module tgf_slot_pool #(
   parameter int CAPACITY = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tgf_pkg::pool_ctrl_type        ctrl,
   input  logic [$clog2(CAPACITY)-1:0]   give_slot,
   output logic [$clog2(CAPACITY)-1:0]   alloc_slot,
   output logic                          none_free
);
   import tgf_pkg::*;

   localparam int SW = $clog2(CAPACITY);

   logic [SW-1:0] stack_mem [CAPACITY];
   logic [SW-1:0] stack_q_ff;
   logic [SW-1:0] hw_slot_ff;
   logic [SW:0]   sp_ff;
   logic [SW:0]   hw_ff;
   logic          pop_ff;
   logic [SW:0]   sp_dec;

   assign sp_dec     = sp_ff - 1'b1;
   assign none_free  = (sp_ff == '0) && (hw_ff == (SW+1)'(CAPACITY));
   assign alloc_slot = pop_ff ? stack_q_ff : hw_slot_ff;

   always_ff @(posedge clock) begin
      if (ctrl.give_back) begin
         stack_mem[sp_ff[SW-1:0]] <= give_slot;
      end
      if (ctrl.alloc) begin
         stack_q_ff <= stack_mem[sp_dec[SW-1:0]];
         hw_slot_ff <= hw_ff[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.flush) begin
         sp_ff  <= '0;
         hw_ff  <= '0;
         pop_ff <= 1'b0;
      end else begin
         if (ctrl.alloc) begin
            if (sp_ff != '0) begin
               sp_ff  <= sp_dec;
               pop_ff <= 1'b1;
            end else begin
               hw_ff  <= hw_ff + 1'b1;
               pop_ff <= 1'b0;
            end
         end
         if (ctrl.give_back) begin
            sp_ff <= sp_ff + 1'b1;
         end
      end
   end

endmodule

// ----- design/tgf_checker.sv -----
// Port-level checks of the team grouped FIFO core, bound into the core module.
module tgf_port_checker #(
   parameter int ELEMENT_BITS = 10
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [1:0]              req_cmd,
   input logic                    rsp_strobe,
   input logic [ELEMENT_BITS-1:0] rsp_element_out,
   input logic [1:0]              rsp_status
);
   import tgf_pkg::*;

   logic accept;

   assign accept = start && !busy;

   a_reset_sweeps: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_set_silent: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_SET) |=> !rsp_strobe)
      else $error("membership load produced an item");

   a_queue_answers: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_cmd == CMD_ENQ) || (req_cmd == CMD_DEQ)) |=> rsp_strobe || busy)
      else $error("queue command neither answered nor in progress");

   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_CLR) |=> busy && !rsp_strobe)
      else $error("clear did not start the sweep");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_OK) |-> rsp_element_out == '0)
      else $error("error item carries an element");

endmodule

bind team_grouped_fifo_core tgf_port_checker #(
   .ELEMENT_BITS(ELEMENT_BITS)
) u_tgf_checker (.*);

// ----- tb/tgf_checker.sv -----
`timescale 1ns / 1ps
// Watches the command and answer ports of the team grouped FIFO, predicts answers and checks them.
module tgf_checker
   import tgf_pkg::*;
#(
   parameter int TEAMS        = 16,
   parameter int ELEMENT_BITS = 10,
   parameter int CAPACITY     = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [1:0]              req_cmd,
   input  logic [ELEMENT_BITS-1:0] req_element,
   input  logic [3:0]              req_team,
   input  logic                    rsp_strobe,
   input  logic [ELEMENT_BITS-1:0] rsp_element_out,
   input  logic [1:0]              rsp_status,
   output int unsigned             pending,
   output int unsigned             mismatches
);

   typedef struct packed {
      logic [ELEMENT_BITS-1:0] element;
      status_type              status;
   } answer_t;

   answer_t answers_due[$];

   logic [3:0]              team_of_element [1 << ELEMENT_BITS];
   logic [ELEMENT_BITS-1:0] element_store [CAPACITY];
   logic [7:0]              next_link [CAPACITY];
   logic [7:0]              free_ring [CAPACITY];
   logic [7:0]              free_rd;
   logic [8:0]              free_count;
   logic [7:0]              group_head [TEAMS];
   logic [7:0]              group_tail [TEAMS];
   logic                    team_waiting [TEAMS];
   logic [3:0]              team_order [TEAMS];
   logic [3:0]              order_head;
   logic [4:0]              order_count;

   function automatic void wipe_queues();
      for (int i = 0; i < (1 << ELEMENT_BITS); i++) team_of_element[i] = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         element_store[i] = '0;
         next_link[i]     = '0;
         free_ring[i]     = i[7:0];
      end
      for (int i = 0; i < TEAMS; i++) begin
         group_head[i]   = '0;
         group_tail[i]   = '0;
         team_waiting[i] = 1'b0;
         team_order[i]   = '0;
      end
      free_rd     = '0;
      free_count  = 9'(CAPACITY);
      order_head  = '0;
      order_count = '0;
   endfunction

   function automatic void serve_command(cmd_type c, logic [ELEMENT_BITS-1:0] e,
                                         logic [3:0] t);
      logic [3:0] grp;
      logic [7:0] slot;
      answer_t    ans;
      ans = '{element: '0, status: ST_OK};
      case (c)
         CMD_SET: begin
            team_of_element[e] = t;
         end
         CMD_ENQ: begin
            if (free_count == 0) begin
               ans.status = ST_FULL;
            end else begin
               grp = team_of_element[e];
               slot = free_ring[free_rd];
               free_rd = free_rd + 8'd1;
               free_count = free_count - 9'd1;
               element_store[slot] = e;
               next_link[slot] = slot;
               if (team_waiting[grp]) begin
                  next_link[group_tail[grp]] = slot;
                  group_tail[grp] = slot;
               end else begin
                  group_head[grp] = slot;
                  group_tail[grp] = slot;
                  team_waiting[grp] = 1'b1;
                  team_order[order_head + order_count[3:0]] = grp;
                  order_count = order_count + 5'd1;
               end
            end
            answers_due.insert(answers_due.size(), ans);
         end
         CMD_DEQ: begin
            if (order_count == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               grp = team_order[order_head];
               slot = group_head[grp];
               ans.element = element_store[slot];
               free_ring[free_rd + free_count[7:0]] = slot;
               free_count = free_count + 9'd1;
               if (slot == group_tail[grp]) begin
                  team_waiting[grp] = 1'b0;
                  order_head = order_head + 4'd1;
                  order_count = order_count - 5'd1;
               end else begin
                  group_head[grp] = next_link[slot];
               end
            end
            answers_due.insert(answers_due.size(), ans);
         end
         default: begin
            wipe_queues();
         end
      endcase
   endfunction

   always @(posedge clock) begin
      answer_t due;
      if (reset) begin
         wipe_queues();
         answers_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               $display("%0t: answer with none due, element_out %0d status %0d",
                        $time, rsp_element_out, rsp_status);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_element_out !== due.element) begin
                  $display("%0t: element_out expected %0d, got %0d",
                           $time, due.element, rsp_element_out);
                  mismatches++;
               end
               if (rsp_status !== due.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, due.status, rsp_status);
                  mismatches++;
               end
            end
         end
         if (start && !busy) serve_command(cmd_type'(req_cmd), req_element, req_team);
      end
      pending = answers_due.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the team grouped FIFO core.
module tb_top;
   import tgf_pkg::*;

   localparam int ITEMS = 1300;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [9:0]  req_element;
   logic [3:0]  req_team;
   logic        rsp_strobe;
   logic [9:0]  rsp_element_out;
   logic [1:0]  rsp_status;
   int unsigned pending;
   int unsigned mismatches;
   int          sent;
   bit          quiet;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   team_grouped_fifo_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_element     (req_element),
      .req_team        (req_team),
      .rsp_strobe      (rsp_strobe),
      .rsp_element_out (rsp_element_out),
      .rsp_status      (rsp_status)
   );

   tgf_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_element     (req_element),
      .req_team        (req_team),
      .rsp_strobe      (rsp_strobe),
      .rsp_element_out (rsp_element_out),
      .rsp_status      (rsp_status),
      .pending         (pending),
      .mismatches      (mismatches)
   );

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic issue(input cmd_type c, input logic [9:0] e, input logic [3:0] t);
      int gap;
      gap = quiet ? 0 : idle_cycles();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd     <= c;
      req_element <= e;
      req_team    <= t;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   // hold the sender until every answer is in
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      logic [9:0] roster [12];
      int         n;
      int         tmax;
      int         enq_pct;
      int         ops;
      int         r;
      bit         filled;
      start       <= 1'b0;
      reset       <= 1'b1;
      req_cmd     <= CMD_SET;
      req_element <= '0;
      req_team    <= '0;
      quiet  = 1'b0;
      sent   = 0;
      filled = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_DEQ, 10'd0, 4'd0);
      issue(CMD_SET, 10'd1023, 4'd15);
      issue(CMD_SET, 10'd0, 4'd0);
      issue(CMD_SET, 10'd512, 4'd8);
      issue(CMD_ENQ, 10'd1023, 4'd0);
      issue(CMD_ENQ, 10'd5, 4'd15);
      issue(CMD_ENQ, 10'd1023, 4'd7);
      issue(CMD_ENQ, 10'd512, 4'd0);
      issue(CMD_ENQ, 10'd0, 4'd0);
      issue(CMD_SET, 10'd1023, 4'd3);
      issue(CMD_ENQ, 10'd1023, 4'd0);
      issue(CMD_DEQ, 10'd1023, 4'd15);
      issue(CMD_DEQ, 10'd0, 4'd0);
      issue(CMD_DEQ, 10'd0, 4'd0);
      issue(CMD_DEQ, 10'd0, 4'd0);
      issue(CMD_DEQ, 10'd0, 4'd0);
      issue(CMD_DEQ, 10'd0, 4'd0);
      issue(CMD_DEQ, 10'd0, 4'd0);
      issue(CMD_ENQ, 10'd1023, 4'd0);
      issue(CMD_CLR, 10'd1023, 4'd15);
      issue(CMD_ENQ, 10'd1023, 4'd0);
      issue(CMD_DEQ, 10'd0, 4'd0);
      issue(CMD_DEQ, 10'd0, 4'd0);

      while (sent < ITEMS) begin
         if (!filled && sent >= 400) begin
            // run the pool full, then empty it again
            drain();
            issue(CMD_CLR, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
            for (int i = 0; i < 8; i++) begin
               roster[i] = 10'($urandom_range(0, 1023));
               issue(CMD_SET, roster[i], 4'($urandom_range(0, 15)));
            end
            repeat (260) begin
               if ($urandom_range(0, 3) == 0)
                  issue(CMD_ENQ, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
               else
                  issue(CMD_ENQ, roster[$urandom_range(0, 7)], 4'($urandom_range(0, 15)));
            end
            repeat (262) issue(CMD_DEQ, 10'($urandom_range(0, 1023)),
                               4'($urandom_range(0, 15)));
            filled = 1'b1;
         end else begin
            n    = $urandom_range(2, 12);
            tmax = $urandom_range(0, 15);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++) begin
               roster[i] = 10'($urandom_range(0, 1023));
               issue(CMD_SET, roster[i], 4'($urandom_range(0, tmax)));
            end
            enq_pct = $urandom_range(35, 70);
            ops     = $urandom_range(20, 80);
            repeat (ops) begin
               r = $urandom_range(0, 99);
               if (r < enq_pct)
                  issue(CMD_ENQ, roster[$urandom_range(0, n - 1)], 4'($urandom_range(0, 15)));
               else if (r < 96)
                  issue(CMD_DEQ, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
               else if (r < 99)
                  issue(CMD_SET, roster[$urandom_range(0, n - 1)], 4'($urandom_range(0, 15)));
               else
                  issue(CMD_ENQ, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
            end
            quiet = 1'b0;
            if ($urandom_range(0, 2) == 0) drain();
            if ($urandom_range(0, 1) == 0)
               issue(CMD_CLR, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
         end
      end

      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
design/tgf_pkg.sv
design/tgf_slot_pool.sv
design/team_grouped_fifo_core.sv
design/tgf_checker.sv
tb/tgf_checker.sv
tb/tb_top.sv
